[src/fmbq_pkg.sv]
// Package for the front/middle/back queue: sizes, codes, state encoding
// and ring index helpers. No dependencies.
`default_nettype none

package fmbq_pkg;

  localparam int HalfDepth = 512;
  localparam int ItemWidth = 32;
  localparam int IdxW      = $clog2(HalfDepth);
  localparam int CntW      = $clog2(HalfDepth + 1);

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [CntW-1:0]      cnt_t;
  typedef logic [CntW:0]        sum_t;
  typedef logic [ItemWidth-1:0] item_t;

  localparam cnt_t HalfCnt = cnt_t'(HalfDepth);

  typedef enum logic [1:0] {
    OpPushBack  = 2'd0,
    OpInsertMid = 2'd1,
    OpPopFront  = 2'd2,
    OpPeekFront = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StsOk    = 2'd0,
    StsEmpty = 2'd1,
    StsFull  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    StIdle,
    StShift,
    StPeek,
    StHold
  } state_e;

  // (a + b) mod HalfDepth, a < HalfDepth, b <= HalfDepth
  function automatic idx_t ring_add(idx_t a, cnt_t b);
    sum_t s;
    s = sum_t'(a) + sum_t'(b);
    if (s >= sum_t'(HalfDepth)) begin
      s = s - sum_t'(HalfDepth);
    end
    return idx_t'(s);
  endfunction

  // (a - 1) mod HalfDepth
  function automatic idx_t ring_dec(idx_t a);
    idx_t r;
    if (a == '0) begin
      r = idx_t'(HalfDepth - 1);
    end else begin
      r = a - idx_t'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/fmbq_if.sv]
// Valid/ready channel interfaces for the queue's request and response beats.
// Depends on fmbq_pkg.
`default_nettype none

interface fmbq_req_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [fmbq_pkg::ItemWidth-1:0] item_tag;

  modport source (output valid, output opcode, output item_tag, input ready);
  modport sink   (input valid, input opcode, input item_tag, output ready);
endinterface

interface fmbq_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [fmbq_pkg::ItemWidth-1:0] front_tag;
  logic [1:0]             status;

  modport source (output valid, output front_tag, output status, input ready);
  modport sink   (input valid, input front_tag, input status, output ready);
endinterface

`default_nettype wire

[src/fmbq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fmbq_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/front_middle_back_queue.sv]
// Top level of the front/middle/back queue.
// Depends on fmbq_pkg, fmbq_if (fmbq_req_if, fmbq_rsp_if) and fmbq_ram.
`default_nettype none

// Queue of 32-bit tags split into a front half and a back half, each in its
// own ring RAM of HalfDepth entries; the front half always holds as many
// items as the back half or one more. Request beats carry an opcode (push
// back, insert middle, pop front, peek front) and a tag. Pop or peek on an
// empty queue and push or insert on a full queue (both halves at HalfDepth)
// give one response beat with status empty or full; a peek gives the front
// tag with status ok; all other operations give no response. An operation
// that needs no RAM read (plain push, insert, pop, and every empty/full
// rejection) finishes in the idle state, so such beats can come every cycle
// while no response is held. A peek, and a push or pop that moves the
// first back item to the front half, reads a ring RAM; the reads are
// registered, so the read is issued when the beat is accepted and the data
// is used (written to the front ring, or loaded as the response) next cycle.
// Responses go through an output register; if it is still occupied when a
// response is ready, the block holds it and takes no new beat until the
// register frees. No clearing pass: ring contents are only read after
// being written.
module front_middle_back_queue (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fmbq_req_if.sink   req_i,
  fmbq_rsp_if.source rsp_o
);
  import fmbq_pkg::*;

  state_e  state_q, state_d;
  idx_t    ff_q, ff_d;          // front ring first index
  cnt_t    fc_q, fc_d;          // front count
  idx_t    bf_q, bf_d;          // back ring first index
  cnt_t    bc_q, bc_d;          // back count
  idx_t    shift_addr_q, shift_addr_d;

  logic    out_valid_q, out_valid_d;
  item_t   out_tag_q, out_tag_d;
  status_e out_sts_q, out_sts_d;
  item_t   pend_tag_q, pend_tag_d;
  status_e pend_sts_q, pend_sts_d;

  // ring ports
  logic  f_we, f_re, b_we, b_re;
  idx_t  f_waddr, f_raddr, b_waddr, b_raddr;
  item_t f_wdata, b_wdata, f_rdata, b_rdata;

  logic    res_valid;
  item_t   res_tag;
  status_e res_sts;
  logic    slot_free;
  logic    is_full, is_empty;
  op_e     op;

  fmbq_ram #(.Width(ItemWidth), .Depth(HalfDepth)) u_front_ring (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .re_i   (f_re),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  fmbq_ram #(.Width(ItemWidth), .Depth(HalfDepth)) u_back_ring (
    .clk_i  (clk_i),
    .we_i   (b_we),
    .waddr_i(b_waddr),
    .wdata_i(b_wdata),
    .re_i   (b_re),
    .raddr_i(b_raddr),
    .rdata_o(b_rdata)
  );

  assign op        = op_e'(req_i.opcode);
  assign is_full   = (fc_q == HalfCnt) && (bc_q == HalfCnt);
  assign is_empty  = (fc_q == '0);
  assign slot_free = !out_valid_q || rsp_o.ready;

  assign req_i.ready     = (state_q == StIdle);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.front_tag = out_tag_q;
  assign rsp_o.status    = out_sts_q;

  always_comb begin
    state_d      = state_q;
    ff_d         = ff_q;
    fc_d         = fc_q;
    bf_d         = bf_q;
    bc_d         = bc_q;
    shift_addr_d = shift_addr_q;
    pend_tag_d   = pend_tag_q;
    pend_sts_d   = pend_sts_q;
    out_tag_d    = out_tag_q;
    out_sts_d    = out_sts_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;

    f_we = 1'b0; f_waddr = '0; f_wdata = '0;
    f_re = 1'b0; f_raddr = ff_q;
    b_we = 1'b0; b_waddr = '0; b_wdata = '0;
    b_re = 1'b0; b_raddr = bf_q;

    res_valid = 1'b0;
    res_tag   = '0;
    res_sts   = StsOk;

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          case (op)
            OpPushBack: begin
              if (is_full) begin
                res_valid = 1'b1;
                res_sts   = StsFull;
              end else if (fc_q != bc_q) begin
                b_we    = 1'b1;
                b_waddr = ring_add(bf_q, bc_q);
                b_wdata = req_i.item_tag;
                bc_d    = bc_q + cnt_t'(1);
              end else if (bc_q == '0) begin
                // both halves empty: the item lands straight in the front
                f_we    = 1'b1;
                f_waddr = ring_add(ff_q, fc_q);
                f_wdata = req_i.item_tag;
                fc_d    = fc_q + cnt_t'(1);
                bf_d    = ring_add(bf_q, cnt_t'(1));
              end else begin
                // append, then move the first back item to the front
                b_we         = 1'b1;
                b_waddr      = ring_add(bf_q, bc_q);
                b_wdata      = req_i.item_tag;
                b_re         = 1'b1;
                shift_addr_d = ring_add(ff_q, fc_q);
                fc_d         = fc_q + cnt_t'(1);
                bf_d         = ring_add(bf_q, cnt_t'(1));
                state_d      = StShift;
              end
            end
            OpInsertMid: begin
              if (is_full) begin
                res_valid = 1'b1;
                res_sts   = StsFull;
              end else if (fc_q == bc_q) begin
                f_we    = 1'b1;
                f_waddr = ring_add(ff_q, fc_q);
                f_wdata = req_i.item_tag;
                fc_d    = fc_q + cnt_t'(1);
              end else begin
                b_we    = 1'b1;
                b_waddr = ring_dec(bf_q);
                b_wdata = req_i.item_tag;
                bf_d    = ring_dec(bf_q);
                bc_d    = bc_q + cnt_t'(1);
              end
            end
            OpPopFront: begin
              if (is_empty) begin
                res_valid = 1'b1;
                res_sts   = StsEmpty;
              end else begin
                ff_d = ring_add(ff_q, cnt_t'(1));
                if ((fc_q == bc_q) && (bc_q != '0)) begin
                  // front shrank below back: refill from the back head
                  b_re         = 1'b1;
                  shift_addr_d = ring_add(ff_q, fc_q);
                  bf_d         = ring_add(bf_q, cnt_t'(1));
                  bc_d         = bc_q - cnt_t'(1);
                  state_d      = StShift;
                end else begin
                  fc_d = fc_q - cnt_t'(1);
                end
              end
            end
            OpPeekFront: begin
              if (is_empty) begin
                res_valid = 1'b1;
                res_sts   = StsEmpty;
              end else begin
                f_re    = 1'b1;
                state_d = StPeek;
              end
            end
            default: begin
            end
          endcase
        end
      end
      StShift: begin
        f_we    = 1'b1;
        f_waddr = shift_addr_q;
        f_wdata = b_rdata;
        state_d = StIdle;
      end
      StPeek: begin
        res_valid = 1'b1;
        res_tag   = f_rdata;
        res_sts   = StsOk;
      end
      StHold: begin
        res_valid = 1'b1;
        res_tag   = pend_tag_q;
        res_sts   = pend_sts_q;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (res_valid) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        out_tag_d   = res_tag;
        out_sts_d   = res_sts;
        state_d     = StIdle;
      end else begin
        pend_tag_d = res_tag;
        pend_sts_d = res_sts;
        state_d    = StHold;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ff_q        <= '0;
      fc_q        <= '0;
      bf_q        <= '0;
      bc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ff_q        <= ff_d;
      fc_q        <= fc_d;
      bf_q        <= bf_d;
      bc_q        <= bc_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    shift_addr_q <= shift_addr_d;
    out_tag_q    <= out_tag_d;
    out_sts_q    <= out_sts_d;
    pend_tag_q   <= pend_tag_d;
    pend_sts_q   <= pend_sts_d;
  end

endmodule

`default_nettype wire
